FILE: rtl/core/lsl_pkg.sv
// Shared constants, types and fixed-point helpers of the LSTM layer step block.
`timescale 1ns / 1ps
`default_nettype none

package lsl_pkg;

  localparam int GATES      = 4;
  localparam int FRAC_BITS  = 12;
  localparam int DATA_W     = 16;
  localparam int ACC_W      = 40;
  localparam int MAX_IN     = 64;
  localparam int MAX_HID    = 16;
  localparam int IW_AW      = 12;
  localparam int RW_AW      = 10;
  localparam int GS_AW      = 6;
  localparam int GS_DEPTH   = 64;
  localparam int HID_AW     = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] FUNC_IW     = 2'd0;
  localparam logic [1:0] FUNC_RW     = 2'd1;
  localparam logic [1:0] FUNC_BIAS   = 2'd2;
  localparam logic [1:0] FUNC_SAMPLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 8'd1;

  typedef struct packed {
    logic                     we;
    logic [1:0]               func;
    logic [IW_AW-1:0]         addr;
    logic signed [DATA_W-1:0] value;
  } wr_req_t;

  typedef struct packed {
    logic                   we;
    logic [GS_AW-1:0]       waddr;
    logic signed [31:0]     wdata;
    logic [GS_AW-1:0]       raddr;
    logic                   clear;
  } gs_req_t;

  typedef struct packed {
    logic                          start;
    logic                          clear;
    logic [HID_AW-1:0]             unit;
    logic [GATES-1:0][DATA_W-1:0]  pre;
  } cell_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] hidden;
  } cell_sts_t;

  function automatic logic [12:0] sigmoid_pwl(input logic signed [17:0] x);
    logic [17:0] a;
    logic [17:0] y;
    a = x[17] ? 18'(-x) : 18'(x);
    if (a >= 18'd20480) begin
      y = 18'd4096;
    end else if (a >= 18'd9728) begin
      y = (a >> 5) + 18'd3456;
    end else if (a >= 18'd4096) begin
      y = (a >> 3) + 18'd2560;
    end else begin
      y = (a >> 2) + 18'd2048;
    end
    if (x[17]) begin
      y = 18'd4096 - y;
    end
    return y[12:0];
  endfunction

  function automatic logic signed [13:0] tanh_pwl(input logic signed [15:0] x);
    logic [12:0]        s;
    logic signed [14:0] t;
    s = sigmoid_pwl($signed({x[15], x, 1'b0}));
    t = $signed({1'b0, s, 1'b0}) - 15'sd4096;
    return t[13:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    r = v + 40'sd2048;
    q = r >>> FRAC_BITS;
    if (q > 40'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -40'sd32768) begin
      return 16'sh8000;
    end
    return q[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lsl_wstore.sv
// Input weight, recurrent weight and gate bias memories with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module lsl_wstore (
  input  wire logic                             clk_i,
  input  wire lsl_pkg::wr_req_t                 wr_i,
  input  wire logic [lsl_pkg::IW_AW-1:0]        iw_raddr_i,
  input  wire logic [lsl_pkg::RW_AW-1:0]        rw_raddr_i,
  input  wire logic [lsl_pkg::GS_AW-1:0]        b_raddr_i,
  output logic signed [lsl_pkg::DATA_W-1:0]     iw_rdata_o,
  output logic signed [lsl_pkg::DATA_W-1:0]     rw_rdata_o,
  output logic signed [lsl_pkg::DATA_W-1:0]     b_rdata_o
);

  logic signed [lsl_pkg::DATA_W-1:0] iw_mem [2**lsl_pkg::IW_AW];
  logic signed [lsl_pkg::DATA_W-1:0] rw_mem [2**lsl_pkg::RW_AW];
  logic signed [lsl_pkg::DATA_W-1:0] b_mem  [2**lsl_pkg::GS_AW];

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.func == lsl_pkg::FUNC_IW) begin
      iw_mem[wr_i.addr] <= wr_i.value;
    end
    if (wr_i.we && wr_i.func == lsl_pkg::FUNC_RW) begin
      rw_mem[wr_i.addr[lsl_pkg::RW_AW-1:0]] <= wr_i.value;
    end
    if (wr_i.we && wr_i.func == lsl_pkg::FUNC_BIAS) begin
      b_mem[wr_i.addr[lsl_pkg::GS_AW-1:0]] <= wr_i.value;
    end
    iw_rdata_o <= iw_mem[iw_raddr_i];
    rw_rdata_o <= rw_mem[rw_raddr_i];
    b_rdata_o  <= b_mem[b_raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/lsl_gstore.sv
// Gate sum memory with per-entry valid bits so that a clear resets all entries together.
`timescale 1ns / 1ps
`default_nettype none

module lsl_gstore (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lsl_pkg::gs_req_t req_i,
  output logic signed [31:0]    rdata_o
);

  logic signed [31:0]             mem [lsl_pkg::GS_DEPTH];
  logic [lsl_pkg::GS_DEPTH-1:0]   valid_q;
  logic signed [31:0]             rd_q;
  logic                           rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.raddr];
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  assign rdata_o = rd_valid_q ? rd_q : 32'sd0;

endmodule

`default_nettype wire

FILE: rtl/core/lsl_cell.sv
// Activation and cell update unit holding the hidden and cell vectors.
`timescale 1ns / 1ps
`default_nettype none

module lsl_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lsl_pkg::cell_req_t            req_i,
  input  wire logic [lsl_pkg::HID_AW-1:0]    hid_idx_i,
  output logic signed [lsl_pkg::DATA_W-1:0]  hid_rdata_o,
  output lsl_pkg::cell_sts_t                 sts_o
);

  logic signed [lsl_pkg::DATA_W-1:0] hid_q  [lsl_pkg::MAX_HID];
  logic signed [lsl_pkg::DATA_W-1:0] cell_q [lsl_pkg::MAX_HID];
  logic [2:0]                        step_q;
  logic                              done_q;
  logic [lsl_pkg::HID_AW-1:0]        unit_q;
  logic [12:0]                       ig_q, fg_q, og_q;
  logic signed [13:0]                cg_q, t_q;
  logic signed [lsl_pkg::DATA_W-1:0] cold_q, c_q, h_q;
  logic signed [29:0]                m1_q;
  logic signed [27:0]                m2_q, m3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
      done_q <= 1'b0;
      for (int n = 0; n < lsl_pkg::MAX_HID; n++) begin
        hid_q[n]  <= '0;
        cell_q[n] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (req_i.clear) begin
        for (int n = 0; n < lsl_pkg::MAX_HID; n++) begin
          hid_q[n]  <= '0;
          cell_q[n] <= '0;
        end
      end
      unique case (step_q)
        3'd0: begin
          if (req_i.start) begin
            step_q <= 3'd1;
          end
        end
        3'd5: begin
          step_q         <= 3'd0;
          done_q         <= 1'b1;
          cell_q[unit_q] <= c_q;
          hid_q[unit_q]  <= lsl_pkg::round_sat(40'(m3_q));
        end
        default: begin
          step_q <= step_q + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_q)
      3'd0: begin
        unit_q <= req_i.unit;
        ig_q   <= lsl_pkg::sigmoid_pwl(18'(signed'(req_i.pre[0])));
        fg_q   <= lsl_pkg::sigmoid_pwl(18'(signed'(req_i.pre[1])));
        cg_q   <= lsl_pkg::tanh_pwl(signed'(req_i.pre[2]));
        og_q   <= lsl_pkg::sigmoid_pwl(18'(signed'(req_i.pre[3])));
        cold_q <= cell_q[req_i.unit];
      end
      3'd1: begin
        m1_q <= $signed({1'b0, fg_q}) * cold_q;
        m2_q <= $signed({1'b0, ig_q}) * cg_q;
      end
      3'd2: c_q <= lsl_pkg::round_sat(40'(m1_q) + 40'(m2_q));
      3'd3: t_q <= lsl_pkg::tanh_pwl(c_q);
      3'd4: m3_q <= $signed({1'b0, og_q}) * t_q;
      3'd5: h_q <= lsl_pkg::round_sat(40'(m3_q));
      default: ;
    endcase
  end

  assign hid_rdata_o   = hid_q[hid_idx_i];
  assign sts_o.done    = done_q;
  assign sts_o.hidden  = h_q;

endmodule

`default_nettype wire

FILE: rtl/core/lstm_layer_step.sv
// Top level of the LSTM layer step block: sequencer, shared multiplier and ports.
// Usage:
// Write words (func 0, 1, 2) load input weights, recurrent weights and gate
// biases. Sample words (func 3) carry one feature. A sample streams the 4H
// gate sums through the gate memory, one per cycle, on one multiplier, H the
// hidden count. The sample that ends a timestep then runs 4H*H recurrent
// products through the same multiplier and updates each unit through four
// gate memory reads and the activation pipeline. One result word per unit
// leaves through an output register, unit index ascending, last_of_step
// marking the last unit.
// in_ready_o is high while the sequencer waits for a word; a stalled
// receiver holds the sequencer before the next unit is emitted, and the
// last result may wait while a new word is accepted.
// Reset clears the hidden, cell and gate sum state, the feature position and
// sets both count registers to one; weight memories keep their contents.
// Configuration words are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module lstm_layer_step (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         func_i,
  input  wire logic [11:0]                        addr_i,
  input  wire logic signed [15:0]                 value_i,
  input  wire logic                               first_step_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [15:0]                      hidden_value_o,
  output logic [3:0]                              hidden_index_o,
  output logic                                    last_of_step_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [lsl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_MDRAIN = 3'd2;
  localparam logic [2:0] S_REC    = 3'd3;
  localparam logic [2:0] S_RDRAIN = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_CELL   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [6:0]         ic_q;
  logic [4:0]         hc_q;
  logic [6:0]         eff_in;
  logic [4:0]         eff_h;
  logic [6:0]         g_cnt;
  logic [6:0]         pos_q, pos_use;
  logic               lastf_q;
  logic signed [15:0] value_q;
  logic [5:0]         j_q;
  logic [3:0]         i_q, u_q;
  logic [2:0]         k_q;

  logic               s1_v_q, s2_v_q;
  logic [5:0]         s1_j_q, s2_j_q;
  logic signed [31:0] prod_q, g2_q;
  logic               r1_v_q, r1_first_q, r1_last_q;
  logic               r2_v_q, r2_first_q, r2_last_q;
  logic               r3_v_q;
  logic [5:0]         r1_j_q, r2_j_q, r3_j_q;
  logic signed [15:0] h1_q;
  logic signed [39:0] base_q, acc_q;
  logic               f1_v_q;
  logic [1:0]         f1_k_q;
  logic [3:0][15:0]   pre_q;

  logic               out_valid_q, out_last_q;
  logic signed [15:0] out_val_q;
  logic [3:0]         out_idx_q;

  logic               in_acc, is_sample, j_end, i_end, u_end, start_cell, load_out;
  logic [13:0]        iw_idx;
  logic [10:0]        rw_idx;
  logic [6:0]         fetch_idx;
  logic signed [15:0] iw_rd, rw_rd, b_rd, hid_rd;
  logic signed [31:0] gs_rd, mul_p;
  logic signed [39:0] mac_sum;

  lsl_pkg::wr_req_t   wr_req;
  lsl_pkg::gs_req_t   gs_req;
  lsl_pkg::cell_req_t cell_req;
  lsl_pkg::cell_sts_t cell_sts;

  always_comb begin
    if (ic_q == 7'd0) begin
      eff_in = 7'd1;
    end else if (ic_q > 7'(lsl_pkg::MAX_IN)) begin
      eff_in = 7'(lsl_pkg::MAX_IN);
    end else begin
      eff_in = ic_q;
    end
    if (hc_q == 5'd0) begin
      eff_h = 5'd1;
    end else if (hc_q > 5'(lsl_pkg::MAX_HID)) begin
      eff_h = 5'(lsl_pkg::MAX_HID);
    end else begin
      eff_h = hc_q;
    end
  end

  assign g_cnt      = {eff_h, 2'b00};
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_sample  = (func_i == lsl_pkg::FUNC_SAMPLE);
  assign pos_use    = first_step_i ? 7'd0 : pos_q;
  assign j_end      = ({1'b0, j_q} == g_cnt - 7'd1);
  assign i_end      = ({1'b0, i_q} == eff_h - 5'd1);
  assign u_end      = ({1'b0, u_q} == eff_h - 5'd1);
  assign start_cell = (state_q == S_FETCH) && (k_q == 3'd4) && !f1_v_q;
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign iw_idx    = 14'(pos_q) * 14'(g_cnt) + 14'(j_q);
  assign rw_idx    = 11'(i_q) * 11'(g_cnt) + 11'(j_q);
  assign fetch_idx = 7'(k_q[1:0]) * 7'(eff_h) + 7'(u_q);

  assign mul_p   = s1_v_q ? (value_q * iw_rd) : (h1_q * rw_rd);
  assign mac_sum = 40'(g2_q) + 40'(prod_q);

  assign wr_req.we    = in_acc && !is_sample;
  assign wr_req.func  = func_i;
  assign wr_req.addr  = addr_i;
  assign wr_req.value = value_i;

  assign gs_req.we    = s2_v_q || r3_v_q;
  assign gs_req.waddr = s2_v_q ? s2_j_q : r3_j_q;
  assign gs_req.wdata = s2_v_q ? lsl_pkg::sat32(mac_sum)
                               : 32'(lsl_pkg::round_sat(40'(lsl_pkg::sat32(acc_q))));
  assign gs_req.raddr = (state_q == S_FETCH) ? fetch_idx[5:0] : j_q;
  assign gs_req.clear = (in_acc && is_sample && first_step_i) || (load_out && u_end);

  assign cell_req.start = start_cell;
  assign cell_req.clear = in_acc && is_sample && first_step_i;
  assign cell_req.unit  = u_q;
  assign cell_req.pre   = pre_q;

  lsl_wstore u_wstore (
    .clk_i      (clk_i),
    .wr_i       (wr_req),
    .iw_raddr_i (iw_idx[11:0]),
    .rw_raddr_i (rw_idx[9:0]),
    .b_raddr_i  (j_q),
    .iw_rdata_o (iw_rd),
    .rw_rdata_o (rw_rd),
    .b_rdata_o  (b_rd)
  );

  lsl_gstore u_gstore (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (gs_req),
    .rdata_o (gs_rd)
  );

  lsl_cell u_cell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (cell_req),
    .hid_idx_i   (i_q),
    .hid_rdata_o (hid_rd),
    .sts_o       (cell_sts)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && is_sample) state_d = S_MAC;
      S_MAC:    if (j_end) state_d = S_MDRAIN;
      S_MDRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = lastf_q ? S_REC : S_IDLE;
        end
      end
      S_REC:    if (j_end && i_end) state_d = S_RDRAIN;
      S_RDRAIN: if (!r1_v_q && !r2_v_q && !r3_v_q) state_d = S_FETCH;
      S_FETCH:  if (start_cell) state_d = S_CELL;
      S_CELL:   if (cell_sts.done) state_d = S_OUT;
      S_OUT:    if (load_out) state_d = u_end ? S_IDLE : S_FETCH;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ic_q        <= 7'd1;
      hc_q        <= 5'd1;
      pos_q       <= 7'd0;
      j_q         <= 6'd0;
      i_q         <= 4'd0;
      k_q         <= 3'd0;
      u_q         <= 4'd0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      r1_v_q      <= 1'b0;
      r2_v_q      <= 1'b0;
      r3_v_q      <= 1'b0;
      f1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == lsl_pkg::CFG_INPUT_COUNT) begin
          ic_q <= cfg_data_i[6:0];
        end else if (cfg_index_i == lsl_pkg::CFG_HIDDEN_COUNT) begin
          hc_q <= cfg_data_i[4:0];
        end
      end
      s1_v_q <= (state_q == S_MAC);
      s2_v_q <= s1_v_q;
      r1_v_q <= (state_q == S_REC);
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q && r2_last_q;
      f1_v_q <= (state_q == S_FETCH) && !k_q[2];
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && is_sample) begin
            pos_q <= pos_use;
            j_q   <= 6'd0;
          end
        end
        S_MAC: begin
          if (!j_end) j_q <= j_q + 6'd1;
        end
        S_MDRAIN: begin
          if (!s1_v_q && !s2_v_q) begin
            j_q <= 6'd0;
            i_q <= 4'd0;
            if (!lastf_q) pos_q <= pos_q + 7'd1;
          end
        end
        S_REC: begin
          if (i_end) begin
            i_q <= 4'd0;
            if (!j_end) j_q <= j_q + 6'd1;
          end else begin
            i_q <= i_q + 4'd1;
          end
        end
        S_RDRAIN: begin
          u_q <= 4'd0;
          k_q <= 3'd0;
        end
        S_FETCH: begin
          if (!k_q[2]) k_q <= k_q + 3'd1;
        end
        S_CELL: ;
        S_OUT: begin
          if (load_out) begin
            k_q <= 3'd0;
            if (u_end) begin
              pos_q <= 7'd0;
            end else begin
              u_q <= u_q + 4'd1;
            end
          end
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_sample) begin
      value_q <= value_i;
      lastf_q <= ({1'b0, pos_use} + 8'd1 >= {1'b0, eff_in});
    end
    s1_j_q     <= j_q;
    s2_j_q     <= s1_j_q;
    r1_j_q     <= j_q;
    r1_first_q <= (i_q == 4'd0);
    r1_last_q  <= i_end;
    h1_q       <= hid_rd;
    r2_j_q     <= r1_j_q;
    r2_first_q <= r1_first_q;
    r2_last_q  <= r1_last_q;
    r3_j_q     <= r2_j_q;
    f1_k_q     <= k_q[1:0];
    if (s1_v_q || r1_v_q) begin
      prod_q <= mul_p;
    end
    if (s1_v_q) begin
      g2_q <= gs_rd;
    end
    if (r1_v_q) begin
      base_q <= 40'(gs_rd) + (40'(b_rd) <<< lsl_pkg::FRAC_BITS);
    end
    if (r2_v_q) begin
      acc_q <= (r2_first_q ? base_q : acc_q) + 40'(prod_q);
    end
    if (f1_v_q) begin
      pre_q[f1_k_q] <= gs_rd[15:0];
    end
    if (load_out) begin
      out_val_q  <= cell_sts.hidden;
      out_idx_q  <= u_q;
      out_last_q <= u_end;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign hidden_value_o = out_val_q;
  assign hidden_index_o = out_idx_q;
  assign last_of_step_o = out_last_q;

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(s1_v_q || s2_v_q || r1_v_q || r2_v_q || r3_v_q || f1_v_q))
    else $error("sequencer idle with words in flight");

  a_gs_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_req.we |-> (state_q != S_IDLE) && !(s2_v_q && r3_v_q))
    else $error("gate memory write outside a sample or with two sources");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, hidden_index_o} < eff_h))
    else $error("hidden index beyond hidden count");

  a_cell_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_cell |=> (state_q == S_CELL))
    else $error("cell unit started without the sequencer waiting on it");

endmodule

`default_nettype wire

FILE: test/tb_lstm_layer_step.sv
// Self-checking testbench for the LSTM layer step block: random words, stalls and a scoreboard.
`timescale 1ns / 1ps

module tb_lstm_layer_step;

  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE = 400;

  typedef struct {
    logic [1:0] func;
    logic [11:0] addr;
    logic signed [15:0] value;
    logic first;
  } word_t;

  typedef struct {
    logic signed [15:0] hval;
    logic [3:0] hidx;
    logic last;
  } unit_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [11:0] addr = '0;
  logic signed [15:0] value = '0;
  logic first_step = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] hidden_value;
  logic [3:0] hidden_index;
  logic last_of_step;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  word_t pending_words[$];
  unit_out_t expected_units[$];
  int errors = 0;
  int send_idle = 20;
  int recv_idle = 47;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // Shadow state of the layer.
  logic signed [15:0] iw_mem[4096];
  logic signed [15:0] rw_mem[1024];
  logic signed [15:0] bias_mem[64];
  int hid_vec[16];
  int cell_vec[16];
  int gate_acc[64];
  int feat_pos = 0;
  int in_cnt = 1;
  int hid_cnt = 1;

  lstm_layer_step uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .addr_i(addr), .value_i(value), .first_step_i(first_step),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hidden_value_o(hidden_value), .hidden_index_o(hidden_index),
    .last_of_step_o(last_of_step),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int q12_round(longint v);
    return int'(clamp((v + 2048) >>> 12, -32768, 32767));
  endfunction

  function automatic int sig_approx(longint x);
    longint a;
    longint y;
    a = x < 0 ? -x : x;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = (a >>> 5) + 3456;
    else if (a >= 4096) y = (a >>> 3) + 2560;
    else y = (a >>> 2) + 2048;
    return int'(x < 0 ? 4096 - y : y);
  endfunction

  function automatic int tanh_approx(longint x);
    return 2 * sig_approx(2 * x) - 4096;
  endfunction

  function automatic void apply_cfg(logic [lsl_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lsl_pkg::CFG_DATA_W-1:0] d);
    if (idx == lsl_pkg::CFG_INPUT_COUNT) in_cnt = int'(clamp(d[6:0], 1, lsl_pkg::MAX_IN));
    else if (idx == lsl_pkg::CFG_HIDDEN_COUNT)
      hid_cnt = int'(clamp(d[4:0], 1, lsl_pkg::MAX_HID));
  endfunction

  function automatic void step_layer(word_t w);
    int g;
    int pre[64];
    longint s;
    unit_out_t u;
    case (w.func)
      lsl_pkg::FUNC_IW: iw_mem[w.addr] = w.value;
      lsl_pkg::FUNC_RW: rw_mem[w.addr % 1024] = w.value;
      lsl_pkg::FUNC_BIAS: bias_mem[w.addr % 64] = w.value;
      default: begin
        g = 4 * hid_cnt;
        if (w.first) begin
          for (int k = 0; k < 16; k++) begin
            hid_vec[k] = 0;
            cell_vec[k] = 0;
          end
          for (int k = 0; k < 64; k++) gate_acc[k] = 0;
          feat_pos = 0;
        end
        for (int j = 0; j < g; j++) begin
          s = longint'(gate_acc[j]) + longint'(w.value) * iw_mem[(feat_pos * g + j) % 4096];
          gate_acc[j] = int'(clamp(s, -64'sd2147483648, 64'sd2147483647));
        end
        if (feat_pos + 1 < in_cnt) begin
          feat_pos = (feat_pos + 1) & 127;
        end else begin
          for (int j = 0; j < g; j++) begin
            s = longint'(gate_acc[j]) + longint'(bias_mem[j]) * 4096;
            for (int i = 0; i < hid_cnt; i++)
              s += longint'(hid_vec[i]) * rw_mem[(i * g + j) % 1024];
            pre[j] = q12_round(clamp(s, -64'sd2147483648, 64'sd2147483647));
          end
          for (int i = 0; i < hid_cnt; i++) begin
            cell_vec[i] = q12_round(longint'(sig_approx(pre[hid_cnt + i])) * cell_vec[i]
                + longint'(sig_approx(pre[i])) * tanh_approx(pre[2 * hid_cnt + i]));
            hid_vec[i] = q12_round(longint'(sig_approx(pre[3 * hid_cnt + i]))
                * tanh_approx(cell_vec[i]));
            u.hval = 16'(hid_vec[i]);
            u.hidx = 4'(i);
            u.last = (i == hid_cnt - 1);
            expected_units.push_back(u);
          end
          for (int k = 0; k < 64; k++) gate_acc[k] = 0;
          feat_pos = 0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Input driver.
  always @(posedge clk) begin
    word_t w;
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_valid) begin
        w.func = func;
        w.addr = addr;
        w.value = value;
        w.first = first_step;
        step_layer(w);
      end
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
        w = pending_words.pop_front();
        func <= w.func;
        addr <= w.addr;
        value <= w.value;
        first_step <= w.first;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    unit_out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch("unexpected word, unit", hidden_index, -1);
        end else begin
          e = expected_units.pop_front();
          if (hidden_value !== e.hval) report_mismatch("hidden_value", hidden_value, e.hval);
          if (hidden_index !== e.hidx) report_mismatch("hidden_index", hidden_index, e.hidx);
          if (last_of_step !== e.last) report_mismatch("last_of_step", last_of_step, e.last);
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver hold-off, triggered once.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt <= 700;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_lstm_layer_step: errors");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_value();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(4096) - 2048);
  endfunction

  function automatic void add_word(logic [1:0] f, int a, logic signed [15:0] v, logic fs);
    word_t w;
    w.func = f;
    w.addr = 12'(a);
    w.value = v;
    w.first = fs;
    pending_words.push_back(w);
  endfunction

  function automatic void add_random(int samples, int n_in);
    int done_cnt;
    int pick;
    done_cnt = 0;
    while (done_cnt < samples) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        for (int k = 0; k < n_in; k++)
          add_word(lsl_pkg::FUNC_SAMPLE, $urandom, rand_value(),
                   k == 0 && $urandom_range(2) == 0);
        done_cnt += n_in;
      end else if (pick < 90) begin
        add_word(2'($urandom_range(2)), $urandom, rand_value(), 1'($urandom));
      end else begin
        add_word(lsl_pkg::FUNC_SAMPLE, $urandom, 16'($urandom), 1'($urandom));
        done_cnt++;
      end
    end
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_units.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [lsl_pkg::CFG_IDX_W-1:0] idx,
                           logic [lsl_pkg::CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int in_raw, int hid_raw, int samples);
    drain();
    write_cfg(lsl_pkg::CFG_INPUT_COUNT, 16'(in_raw));
    write_cfg(lsl_pkg::CFG_HIDDEN_COUNT, 16'(hid_raw));
    add_random(samples, in_cnt);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Two inputs and two hidden units; every entry that these shapes read is loaded.
    write_cfg(lsl_pkg::CFG_INPUT_COUNT, 16'd2);
    write_cfg(lsl_pkg::CFG_HIDDEN_COUNT, 16'd2);
    for (int a = 0; a < 16; a++) add_word(lsl_pkg::FUNC_IW, a, rand_value(), 1'b0);
    for (int a = 0; a < 16; a++) add_word(lsl_pkg::FUNC_RW, a, rand_value(), 1'b0);
    for (int a = 0; a < 8; a++) add_word(lsl_pkg::FUNC_BIAS, a, rand_value(), 1'b0);
    add_word(lsl_pkg::FUNC_IW, 3, 16'sh7FFF, 1'b0);
    add_word(lsl_pkg::FUNC_IW, 12, 16'sh8000, 1'b1);
    add_word(lsl_pkg::FUNC_RW, 1029, 16'sh8000, 1'b0);
    add_word(lsl_pkg::FUNC_BIAS, 66, 16'sh7FFF, 1'b0);
    add_word(lsl_pkg::FUNC_SAMPLE, 0, 16'sh7FFF, 1'b1);
    add_word(lsl_pkg::FUNC_SAMPLE, 4095, 16'sh8000, 1'b0);
    add_word(lsl_pkg::FUNC_SAMPLE, 0, 16'sh0000, 1'b0);
    add_word(lsl_pkg::FUNC_SAMPLE, 4095, 16'sh7FFF, 1'b0);
    add_word(lsl_pkg::FUNC_SAMPLE, 0, 16'sh8000, 1'b1);
    add_word(lsl_pkg::FUNC_SAMPLE, 0, 16'sh1000, 1'b0);
    add_random(36, in_cnt);
    send_idle = 47;
    recv_idle = 20;
    run_phase(3, 1, 36);
    run_phase(16'h0080, 16'h0020, 12);
    send_idle = 0;
    recv_idle = 0;
    drain();
    // Four hidden units need the rest of the recurrent rows and biases.
    write_cfg(lsl_pkg::CFG_INPUT_COUNT, 16'd1);
    write_cfg(lsl_pkg::CFG_HIDDEN_COUNT, 16'd4);
    for (int a = 16; a < 64; a++) add_word(lsl_pkg::FUNC_RW, a, rand_value(), 1'b0);
    for (int a = 8; a < 16; a++) add_word(lsl_pkg::FUNC_BIAS, a, rand_value(), 1'b0);
    add_random(24, in_cnt);
    hold_go = 1'b1;
    run_phase(16'h0082, 16'h0021, 30);
    drain();
    if (errors == 0) begin
      $display("tb_lstm_layer_step: clean");
    end else begin
      $display("tb_lstm_layer_step: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lsl_pkg.sv
rtl/core/lsl_wstore.sv
rtl/core/lsl_gstore.sv
rtl/core/lsl_cell.sv
rtl/core/lstm_layer_step.sv
test/tb_lstm_layer_step.sv
